@@ hw/rtl/gbt_pkg.sv @@
// gauge bar tile generator: shared types, constants and codes
// used by gbt_muldiv, gauge_bar_tile_generator_core and gbt_checker
// no dependencies
package gbt_pkg;

  // field widths
  localparam int unsigned ValW   = 16;
  localparam int unsigned TileW  = 16;
  localparam int unsigned BarW   = 7;
  localparam int unsigned MidsW  = 6;
  localparam int unsigned LevelW = 9;
  localparam int unsigned FillW  = 10;
  localparam int unsigned ProdW  = LevelW + ValW;
  localparam int unsigned StepW  = 5;

  // bar geometry
  localparam int unsigned MaxWidth  = 64;
  localparam int unsigned CapLevels = 5;
  localparam int unsigned MidLevels = 8;
  localparam int unsigned LeftOfs   = 0;
  localparam int unsigned MidOfs    = 6;
  localparam int unsigned RightOfs  = 15;

  // configuration port
  localparam int unsigned AddrW  = 3;
  localparam int unsigned DataW  = 32;
  localparam logic        RegBarWidth = 1'b0;
  localparam logic        RegBaseTile = 1'b1;
  localparam logic [BarW-1:0]  BarWidthRst = 7'd8;
  localparam logic [TileW-1:0] BaseTileRst = 16'd0;

  // input beat
  typedef struct packed {
    logic [ValW-1:0] current_value;
    logic [ValW-1:0] maximum_value;
  } gbt_in_t;

  // output beat
  typedef struct packed {
    logic [TileW-1:0] tile_number;
    logic             last_tile;
  } gbt_out_t;

  // request to the serial multiply/divide unit
  typedef struct packed {
    logic              start;
    logic [LevelW-1:0] levels;
    logic [ValW-1:0]   multiplicand;
    logic [ValW-1:0]   divisor;
  } gbt_md_req_t;

  // response from the serial multiply/divide unit
  typedef struct packed {
    logic             done;
    logic [FillW-1:0] filled;
  } gbt_md_rsp_t;

  // top level sequencer
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_EMIT = 3'b100
  } gbt_state_e;

  // multiply/divide unit sequencer
  typedef enum logic [2:0] {
    MD_IDLE = 3'b001,
    MD_MUL  = 3'b010,
    MD_DIV  = 3'b100
  } gbt_md_state_e;

endpackage

@@ hw/rtl/gbt_muldiv.sv @@
// bit-serial multiply (levels * current) then restoring divide by maximum
// one multiplier bit or one quotient bit per cycle; depends on gbt_pkg
module gbt_muldiv import gbt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  gbt_md_req_t req_i,
  output gbt_md_rsp_t rsp_o
);

  gbt_md_state_e      st_q, st_d;
  logic [StepW-1:0]   cnt_q, cnt_d;
  logic [LevelW-1:0]  lv_q, lv_d;
  logic [ValW-1:0]    cur_q, cur_d;
  logic [ValW-1:0]    div_q, div_d;
  logic [ProdW-1:0]   acc_q, acc_d;
  logic [ValW-1:0]    rem_q, rem_d;
  logic               done_q, done_d;

  logic [ProdW-1:0]   addend;
  logic [ValW:0]      trial;
  logic               ge;

  // multiplier bit picks the addend, msb first
  assign addend = lv_q[LevelW-1] ? {{LevelW{1'b0}}, cur_q} : '0;
  // shift one dividend bit into the partial remainder
  assign trial  = {rem_q, acc_q[ProdW-1]};
  assign ge     = (trial >= {1'b0, div_q});

  // sequencer and datapath next values
  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    lv_d   = lv_q;
    cur_d  = cur_q;
    div_d  = div_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    done_d = 1'b0;
    case (st_q)
      MD_IDLE: begin
        if (req_i.start) begin
          st_d  = MD_MUL;
          cnt_d = StepW'(LevelW - 1);
          lv_d  = req_i.levels;
          cur_d = req_i.multiplicand;
          div_d = req_i.divisor;
          acc_d = '0;
        end
      end
      MD_MUL: begin
        acc_d = {acc_q[ProdW-2:0], 1'b0} + addend;
        lv_d  = {lv_q[LevelW-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          st_d  = MD_DIV;
          cnt_d = StepW'(ProdW - 1);
          rem_d = '0;
        end
      end
      MD_DIV: begin
        rem_d = ge ? ValW'(trial - {1'b0, div_q}) : trial[ValW-1:0];
        acc_d = {acc_q[ProdW-2:0], ge};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          st_d   = MD_IDLE;
          done_d = 1'b1;
        end
      end
      default: begin
        st_d = MD_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= MD_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // datapath shift registers
  always_ff @(posedge clk_i) begin
    lv_q  <= lv_d;
    cur_q <= cur_d;
    div_q <= div_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.filled = acc_q[FillW-1:0];

endmodule

@@ hw/rtl/gauge_bar_tile_generator_core.sv @@
// gauge bar tile generator top level: config registers, sequencer, tile emitter
// depends on gbt_pkg and gbt_muldiv
//
// Each input beat (current_value, maximum_value) produces one output beat per
// bar position, left cap first, the right cap flagged with last_tile. The bar
// is bar_width tiles wide (clamped to 64, at least the two caps). The filled
// level count levels*current/maximum comes from a bit-serial unit: shift-add
// multiply and then restoring divide; once it is done the item's tiles follow
// one per cycle while the output does not stall. An overfull item (current
// above maximum, a zero maximum counted as one) skips the arithmetic and goes
// straight to emitting. One item is worked on at a time; the next is taken once
// the last tile sits in the output register. bar_width and base_tile live at APB
// byte addresses 0 and 4 and must only be written while the block is idle.
module gauge_bar_tile_generator_core import gbt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // input channel
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  gbt_in_t          in_data_i,
  // output channel
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output gbt_out_t         out_data_o,
  // configuration port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  gbt_state_e         st_q, st_d;
  logic [BarW-1:0]    bar_width_q;
  logic [TileW-1:0]   base_tile_q;
  logic [MidsW-1:0]   mids_q, mids_d;
  logic [BarW-1:0]    pos_q, pos_d;
  logic [FillW-1:0]   remain_q, remain_d;
  logic               out_valid_q, out_valid_d;
  gbt_out_t           out_data_q, out_data_d;

  logic               cfg_wr;
  logic               in_fire;
  logic [BarW-1:0]    width_clamp;
  logic [MidsW-1:0]   mids;
  logic [LevelW-1:0]  levels;
  logic [ValW-1:0]    max_fix;
  logic               overfull;
  gbt_md_req_t        md_req;
  gbt_md_rsp_t        md_rsp;
  logic               is_left;
  logic               is_right;
  logic [3:0]         tile_lv;
  logic [3:0]         take;
  logic [4:0]         ofs_base;
  logic [4:0]         ofs;
  logic               emit;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bar_width_q <= BarWidthRst;
      base_tile_q <= BaseTileRst;
    end else if (cfg_wr) begin
      case (paddr[2])
        RegBarWidth: bar_width_q <= pwdata[BarW-1:0];
        RegBaseTile: base_tile_q <= pwdata[TileW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegBarWidth: prdata = {{(DataW-BarW){1'b0}}, bar_width_q};
      RegBaseTile: prdata = {{(DataW-TileW){1'b0}}, base_tile_q};
      default:     prdata = '0;
    endcase
  end

  // bar geometry from the width register
  assign width_clamp = (bar_width_q > BarW'(MaxWidth)) ? BarW'(MaxWidth) : bar_width_q;
  assign mids        = (width_clamp < BarW'(2)) ? '0 : MidsW'(width_clamp - BarW'(2));
  assign levels      = {mids, 3'b000} + LevelW'(2 * CapLevels);

  // input beat handling
  assign in_stall_o = ~st_q[0];
  assign in_fire    = in_valid_i & ~in_stall_o;
  assign max_fix    = (in_data_i.maximum_value == '0) ? ValW'(1) : in_data_i.maximum_value;
  assign overfull   = (in_data_i.current_value > max_fix);

  assign md_req.start        = in_fire & ~overfull;
  assign md_req.levels       = levels;
  assign md_req.multiplicand = in_data_i.current_value;
  assign md_req.divisor      = max_fix;

  gbt_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  // tile offset for the current position
  assign is_left  = (pos_q == '0);
  assign is_right = (pos_q == ({1'b0, mids_q} + BarW'(1)));
  assign tile_lv  = (is_left | is_right) ? 4'(CapLevels) : 4'(MidLevels);
  assign take     = (remain_q > {6'b0, tile_lv}) ? tile_lv : remain_q[3:0];
  assign ofs_base = is_left ? 5'(LeftOfs) : (is_right ? 5'(RightOfs) : 5'(MidOfs));
  assign ofs      = ofs_base + {1'b0, take};
  assign emit     = st_q[2] & (~out_valid_q | ~out_stall_i);

  // sequencer and emitter
  always_comb begin
    st_d        = st_q;
    mids_d      = mids_q;
    pos_d       = pos_q;
    remain_d    = remain_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_data_d  = out_data_q;
    case (st_q)
      ST_IDLE: begin
        if (in_fire) begin
          mids_d = mids;
          pos_d  = '0;
          if (overfull) begin
            remain_d = {1'b0, levels};
            st_d     = ST_EMIT;
          end else begin
            st_d = ST_CALC;
          end
        end
      end
      ST_CALC: begin
        if (md_rsp.done) begin
          remain_d = md_rsp.filled;
          st_d     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit) begin
          out_valid_d            = 1'b1;
          out_data_d.tile_number = base_tile_q + {{(TileW-5){1'b0}}, ofs};
          out_data_d.last_tile   = is_right;
          remain_d               = remain_q - {6'b0, take};
          pos_d                  = pos_q + BarW'(1);
          if (is_right) begin
            st_d = ST_IDLE;
          end
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      pos_q       <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      pos_q       <= pos_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    mids_q     <= mids_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ hw/rtl/gbt_checker.sv @@
// port-level checks for gauge_bar_tile_generator_core, attached by bind
// depends on gbt_pkg
module gbt_checker import gbt_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input gbt_out_t out_data_o
);

  // a taken input beat starts work, so no second beat right behind it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken back to back");

  // a stalled output beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output beat changed");

  // output valid only drops after a beat was taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(!out_stall_i))
    else $error("output beat dropped");

  // while idle with nothing pending, no tile appears from nowhere
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o && !out_valid_o |=> !out_valid_o)
    else $error("tile emitted without an item");

endmodule

bind gauge_bar_tile_generator_core gbt_checker u_gbt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

@@ verif/gauge_bar_tile_generator_core_test.sv @@
`timescale 1ns / 100ps
// self-checking bench for gauge_bar_tile_generator_core: bursty input driver, stalling sink,
// tile predictor and in-order beat checker, with config writes over apb between phases
// depends on gbt_pkg and the core rtl
module gauge_bar_tile_generator_core_test;
  import gbt_pkg::*;

  localparam int unsigned      ClkPeriod    = 8;
  localparam logic [AddrW-1:0] BarWidthAddr = {RegBarWidth, 2'b00};
  localparam logic [AddrW-1:0] BaseTileAddr = {RegBaseTile, 2'b00};
  localparam int unsigned      RandomItems  = 420;
  localparam int unsigned      DirectedItems = 22;

  // clock, reset and block inputs, all known from time zero
  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  gbt_in_t          in_beat   = '0;
  logic             out_stall = 1'b0;
  logic             psel      = 1'b0;
  logic             penable   = 1'b0;
  logic             pwrite    = 1'b0;
  logic [AddrW-1:0] paddr     = '0;
  logic [DataW-1:0] pwdata    = '0;

  logic             in_stall;
  logic             out_valid;
  gbt_out_t         out_beat;
  logic [DataW-1:0] prdata;
  logic             pready;

  // bench state
  gbt_in_t          pending_beats[$];
  gbt_out_t         expected_tiles[$];
  logic [BarW-1:0]  cfg_width = BarWidthRst;
  logic [TileW-1:0] cfg_base  = BaseTileRst;
  logic             in_taken  = 1'b0;
  int unsigned      mismatch_count = 0;

  gauge_bar_tile_generator_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_beat),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // total level count of a bar, width clamped as the block does
  function automatic int unsigned bar_levels(input logic [BarW-1:0] width);
    int unsigned w;
    w = (width > MaxWidth) ? MaxWidth : width;
    return (w < 2) ? 2 * CapLevels : 2 * CapLevels + (w - 2) * MidLevels;
  endfunction

  function automatic void push_tile(input int unsigned ofs, input logic last);
    gbt_out_t t;
    t.tile_number = TileW'(cfg_base + ofs);
    t.last_tile   = last;
    expected_tiles.push_back(t);
  endfunction

  // expected tile beats for one input beat, left cap first
  function automatic void predict_bar(input gbt_in_t beat);
    int unsigned w, mids, levels, divisor, filled, rest, mid_full, mid_part, mid_top, ofs, i;
    w       = (cfg_width > MaxWidth) ? MaxWidth : cfg_width;
    mids    = (w < 2) ? 0 : w - 2;
    levels  = bar_levels(cfg_width);
    divisor = (beat.maximum_value == 0) ? 1 : beat.maximum_value;
    if (beat.current_value > divisor) filled = levels;
    else filled = (levels * beat.current_value) / divisor;

    // left cap
    push_tile(LeftOfs + ((filled > CapLevels) ? CapLevels : filled), 1'b0);

    // middle tiles: full, one partial, then empty
    rest     = (filled > CapLevels) ? filled - CapLevels : 0;
    mid_full = rest / MidLevels;
    mid_part = rest % MidLevels;
    for (i = 0; i < mids; i++) begin
      if (i < mid_full) ofs = MidOfs + MidLevels;
      else if (i == mid_full) ofs = MidOfs + mid_part;
      else ofs = MidOfs;
      push_tile(ofs, 1'b0);
    end

    // right cap
    mid_top = CapLevels + mids * MidLevels;
    if (filled < mid_top) ofs = RightOfs;
    else ofs = RightOfs + ((filled - mid_top >= CapLevels) ? CapLevels : filled - mid_top);
    push_tile(ofs, 1'b1);
  endfunction

  function automatic void add_beat(input logic [ValW-1:0] cur, input logic [ValW-1:0] maxv);
    gbt_in_t b;
    b.current_value = cur;
    b.maximum_value = maxv;
    pending_beats.push_back(b);
  endfunction

  // random beat, weighted toward level boundaries, saturation and zero maximum
  function automatic gbt_in_t random_beat(input int unsigned levels);
    gbt_in_t b;
    b.maximum_value = ValW'($urandom);
    b.current_value = ValW'($urandom);
    case ($urandom_range(0, 9))
      0, 1: begin
        b.maximum_value = ValW'(levels);
        b.current_value = ValW'($urandom_range(0, levels));
      end
      2: b.current_value = b.maximum_value;
      3: b.current_value = ValW'($urandom_range(b.maximum_value, 16'hFFFF));
      4: begin
        b.maximum_value = '0;
        b.current_value = ValW'($urandom_range(0, 3));
      end
      5: begin
        b.maximum_value = ValW'($urandom_range(1, 4 * levels));
        b.current_value = ValW'($urandom_range(0, b.maximum_value));
      end
      6, 7: b.current_value = ValW'($urandom_range(0, b.maximum_value));
      default: ;
    endcase
    return b;
  endfunction

  // apb write then read back of one register
  task automatic program_reg(input logic [AddrW-1:0] addr, input logic [DataW-1:0] value);
    logic [DataW-1:0] readback;
    int rd;
    readback = '0;
    for (rd = 0; rd < 2; rd++) begin
      @(negedge clk);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= (rd == 0);
      paddr   <= addr;
      pwdata  <= value;
      @(negedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      if (rd == 1) readback = prdata;
      @(negedge clk);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (rd == 0) begin
        if (addr == BarWidthAddr) cfg_width = value[BarW-1:0];
        else cfg_base = value[TileW-1:0];
      end
    end
    if (addr == BarWidthAddr && readback[BarW-1:0] !== cfg_width) begin
      $error("bar_width: expected %0d, got %0d", cfg_width, readback[BarW-1:0]);
      mismatch_count++;
    end
    if (addr == BaseTileAddr && readback[TileW-1:0] !== cfg_base) begin
      $error("base_tile: expected %0d, got %0d", cfg_base, readback[TileW-1:0]);
      mismatch_count++;
    end
  endtask

  // block until every beat is sent and every tile has come back
  task automatic wait_idle(input int unsigned drain);
    do @(posedge clk);
    while (pending_beats.size() != 0 || in_valid || expected_tiles.size() != 0);
    repeat (drain) @(posedge clk);
  endtask

  // input driver: bursts of beats with random gaps
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (pending_beats.size() != 0) begin
        in_valid <= 1'b1;
        in_beat  <= pending_beats.pop_front();
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7:        gap_left = 0;
            8, 9, 10, 11, 12, 13, 14, 15:  gap_left = $urandom_range(1, 4);
            16, 17, 18:                    gap_left = $urandom_range(5, 40);
            default:                       gap_left = $urandom_range(41, 120);
          endcase
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output stall: free-running, coin-flip or long runs, mode switched now and then
  int unsigned stall_mode = 0;
  int unsigned mode_left  = 0;
  int unsigned run_left   = 0;
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(20, 300);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= 1'($urandom_range(0, 1));
      default: begin
        if (run_left == 0) begin
          out_stall <= ~out_stall;
          run_left = $urandom_range(1, 16);
        end else begin
          run_left--;
        end
      end
    endcase
  end

  // input monitor: predict tiles for every accepted beat
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) predict_bar(in_beat);
    end
  end

  // output monitor: compare each tile beat with the oldest expectation
  always @(posedge clk) begin : tile_checker
    gbt_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_tiles.size() == 0) begin
        $error("unexpected tile beat: tile_number %0d, last_tile %0b",
               out_beat.tile_number, out_beat.last_tile);
        mismatch_count++;
      end else begin
        want = expected_tiles.pop_front();
        if (out_beat.tile_number !== want.tile_number) begin
          $error("tile_number: expected %0d, got %0d", want.tile_number, out_beat.tile_number);
          mismatch_count++;
        end
        if (out_beat.last_tile !== want.last_tile) begin
          $error("last_tile: expected %0b, got %0b", want.last_tile, out_beat.last_tile);
          mismatch_count++;
        end
      end
    end
  end

  // stimulus and phases
  initial begin : stimulus
    logic [BarW-1:0]  width;
    logic [TileW-1:0] base;
    int unsigned      rand_items, phase, count, lv, n;
    // directed beats count toward the item total
    rand_items = DirectedItems;
    phase      = 0;
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed beats at the reset width of 8 (58 levels)
    add_beat(16'd0, 16'd0);
    add_beat(16'd1, 16'd0);
    add_beat(16'd2, 16'd0);
    add_beat(16'd0, 16'hFFFF);
    add_beat(16'hFFFF, 16'hFFFF);
    add_beat(16'hFFFF, 16'd0);
    add_beat(16'hFFFF, 16'hFFFE);
    add_beat(16'hFFFE, 16'hFFFF);
    add_beat(16'd1, 16'hFFFF);
    add_beat(16'hAAAA, 16'h5555);
    add_beat(16'h5555, 16'hAAAA);
    add_beat(16'h8000, 16'hFFFF);
    add_beat(16'd4, 16'd58);
    add_beat(16'd5, 16'd58);
    add_beat(16'd6, 16'd58);
    add_beat(16'd12, 16'd58);
    add_beat(16'd13, 16'd58);
    add_beat(16'd14, 16'd58);
    add_beat(16'd52, 16'd58);
    add_beat(16'd53, 16'd58);
    add_beat(16'd57, 16'd58);
    add_beat(16'd58, 16'd58);
    wait_idle(8);

    // random phases, extreme settings first
    while (rand_items < RandomItems) begin
      base = TileW'($urandom);
      case (phase)
        0: begin width = 7'd0;   base = 16'hFFFF; end
        1: begin width = 7'd1;   base = 16'hFFF0; end
        2: begin width = 7'd2;   base = 16'd0;    end
        3: begin width = 7'd64;  base = 16'hFFEC; end
        4: width = 7'd127;
        5: begin width = 7'd65;  base = 16'h8000; end
        6: begin width = 7'd3;   base = 16'hFFFB; end
        default: begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: width = BarW'($urandom_range(2, 12));
            7, 8:                width = BarW'($urandom_range(13, 64));
            default:             width = BarW'($urandom_range(0, 127));
          endcase
        end
      endcase
      program_reg(BarWidthAddr, DataW'(width));
      program_reg(BaseTileAddr, DataW'(base));
      lv    = bar_levels(width);
      count = (width > 32) ? 10 : 30;
      add_beat(16'd0, ValW'(lv));
      add_beat(ValW'(lv), ValW'(lv));
      for (n = 0; n < count; n++) pending_beats.push_back(random_beat(lv));
      rand_items += count + 2;
      phase++;
      wait_idle(8);
    end

    wait_idle(100);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
